/* rtl/shsort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsort_pkg
// Word types and the fixed gap sequence shared by the Shell sorter modules.
// ----------------------------------------------------------------------------
package shsort_pkg;

    localparam int VALUE_W   = 32;
    localparam int GAP_W     = 11;
    localparam int GAP_COUNT = 6;
    localparam int GAP_IDX_W = 3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } shsort_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_res;
    } shsort_out_t;

    // Gap sequence, largest first.
    function automatic logic [GAP_W-1:0] gap_at(input logic [GAP_IDX_W-1:0] idx);
        logic [GAP_W-1:0] h;
        case (idx)
            3'd0:    h = 11'd2047;
            3'd1:    h = 11'd701;
            3'd2:    h = 11'd31;
            3'd3:    h = 11'd15;
            3'd4:    h = 11'd4;
            3'd5:    h = 11'd1;
            default: h = 11'd1;
        endcase
        return h;
    endfunction

endpackage : shsort_pkg
`default_nettype wire

/* rtl/shell_sorter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Loading takes one word per cycle into an element memory with one write and one read port.
// Sorting inserts each element once per gap (read the key, then probe and shift larger ones up),
// bounded by the one read and one write the memory allows each cycle, after a gap-select step.
// Read-back passes each sorted word through a memory read, then the output register.
// Reset clears the fill count and returns to loading; memory contents are not cleared.
// ----------------------------------------------------------------------------
// shell_sorter
// Collects signed words until one marked last, sorts them ascending by
// Shell sort and sends them back out through an output register.
// ----------------------------------------------------------------------------
module shell_sorter #(
    parameter int DEPTH = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire shsort_pkg::shsort_in_t s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output shsort_pkg::shsort_out_t     m_data
);
    import shsort_pkg::*;

    logic        res_valid;
    logic        res_ready;
    shsort_out_t res_word;
    logic        m_valid_reg;
    shsort_out_t m_data_reg;

    shsort_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // The output register frees the engine to start loading while the final
    // word still waits downstream.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_data_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : shell_sorter
`default_nettype wire

/* rtl/shsort_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsort_engine
// Element memory plus the sequencer that loads, Shell-sorts in place and
// reads the sorted set back out, one memory access of each kind per cycle.
// ----------------------------------------------------------------------------
module shsort_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire shsort_pkg::shsort_in_t in_word,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output shsort_pkg::shsort_out_t     res_word
);
    import shsort_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GAP,
        ST_RKEY,
        ST_KEY,
        ST_CMP,
        ST_PUT,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [GAP_IDX_W-1:0]   g_reg, g_next;
    logic [CW-1:0]          h_reg, h_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [VALUE_W-1:0]     key_reg, key_next;

    logic [VALUE_W-1:0]     mem [DEPTH];
    logic [VALUE_W-1:0]     rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_W-1:0]     wr_data;

    logic [GAP_W-1:0]       gap_h;
    logic [CW-1:0]          i_inc;
    logic [CW-1:0]          i_back;
    logic [CW-1:0]          j_dn;
    logic [CW-1:0]          j_dn_back;
    logic [CW-1:0]          k_inc;
    logic [CW-1:0]          cnt_inc;
    logic                   key_less;
    logic                   last_gap;

    // Element memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign gap_h     = gap_at(g_reg);
    assign i_inc     = i_reg + 1'b1;
    assign i_back    = i_reg - h_reg;
    assign j_dn      = j_reg - h_reg;
    assign j_dn_back = j_dn - h_reg;
    assign k_inc     = k_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign key_less  = $signed(key_reg) < $signed(rd_data_reg);
    assign last_gap  = (g_reg == GAP_IDX_W'(GAP_COUNT - 1));

    assign res_word.sorted_value = rd_data_reg;
    assign res_word.last_res     = (k_inc == n_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        g_next     = g_reg;
        h_next     = h_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    // Words beyond the buffer depth are dropped, but a last
                    // flag on them still starts the sort.
                    if (cnt_reg < CW'(DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[AW-1:0];
                        wr_data  = in_word.value;
                        cnt_next = cnt_inc;
                    end
                    if (in_word.last) begin
                        n_next     = (cnt_reg < CW'(DEPTH)) ? cnt_inc : cnt_reg;
                        cnt_next   = '0;
                        g_next     = '0;
                        state_next = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                if (gap_h < GAP_W'(n_reg)) begin
                    h_next     = gap_h[CW-1:0];
                    i_next     = gap_h[CW-1:0];
                    state_next = ST_RKEY;
                end else if (last_gap) begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    g_next = g_reg + 1'b1;
                end
            end
            ST_RKEY: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                state_next = ST_KEY;
            end
            ST_KEY: begin
                key_next   = rd_data_reg;
                j_next     = i_reg;
                rd_en      = 1'b1;
                rd_addr    = i_back[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP, ST_PUT: begin
                if (state_reg == ST_CMP && key_less) begin
                    // Shift the larger element up by one gap and keep probing.
                    wr_en   = 1'b1;
                    wr_addr = j_reg[AW-1:0];
                    wr_data = rd_data_reg;
                    j_next  = j_dn;
                    if (j_dn >= h_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = j_dn_back[AW-1:0];
                    end else begin
                        state_next = ST_PUT;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[AW-1:0];
                    wr_data = key_reg;
                    if (i_inc < n_reg) begin
                        i_next     = i_inc;
                        state_next = ST_RKEY;
                    end else if (last_gap) begin
                        k_next     = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        g_next     = g_reg + 1'b1;
                        state_next = ST_GAP;
                    end
                end
            end
            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[AW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (k_inc == n_reg) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            n_reg     <= '0;
            g_reg     <= '0;
            h_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            g_reg     <= g_next;
            h_reg     <= h_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
        key_reg <= key_next;
    end

    // The fill count never runs past the buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("shsort_engine: fill count exceeds depth");

    // While probing, the hole is at least one gap above the bottom and
    // never above the element being inserted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (j_reg >= h_reg && j_reg <= i_reg && i_reg < n_reg))
        else $error("shsort_engine: insertion indexes out of order");

    // Every insertion pass runs with a gap below the element count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RKEY) |-> (h_reg != '0 && h_reg < n_reg && i_reg >= h_reg))
        else $error("shsort_engine: pass started with a bad gap");

    // The word flagged last hands the block back to loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res_word.last_res) |=> (state_reg == ST_LOAD))
        else $error("shsort_engine: run did not end after its last word");

    // The read-back never leaves the stored range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT) |-> (k_reg < n_reg))
        else $error("shsort_engine: read-back index beyond the set");

endmodule : shsort_engine
`default_nettype wire
